// ===== hdl/prdr_pkg.sv =====
// Package for the pair distance restraint force block: widths, codes and payload types.
// Used by every module of the block; depends on nothing.
package prdr_pkg;

  localparam int unsigned AtomIndexBits = 16;
  localparam int unsigned FractionBits  = 20;

  localparam int unsigned TagW     = 16;
  localparam int unsigned PosW     = 32;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned SqW      = 66;
  localparam int unsigned SumW     = 67;
  localparam int unsigned RootW    = 33;
  localparam int unsigned SqRemW   = 68;
  localparam int unsigned DispW    = 38;
  localparam int unsigned DMagW    = 35;
  localparam int unsigned MMagW    = 36;
  localparam int unsigned KProdW   = 67;
  localparam int unsigned DedrW    = 47;
  localparam int unsigned DedrLoW  = 24;
  localparam int unsigned DedrHiW  = 23;
  localparam int unsigned EProdW   = 83;
  localparam int unsigned FProdW   = 80;
  localparam int unsigned EnergyW  = 48;
  localparam int unsigned ForceW   = 48;

  typedef enum logic [1:0] {
    RegionInactive = 2'd0,
    RegionHarmonic = 2'd1,
    RegionLinear   = 2'd2,
    RegionZero     = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    CfgRepelMode      = 2'd0,
    CfgForceConstant  = 2'd1,
    CfgFlatLimit      = 2'd2,
    CfgSwitchDistance = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [TagW-1:0]        tag_a;
    logic [TagW-1:0]        tag_b;
    logic signed [PosW-1:0] pos_a_x;
    logic signed [PosW-1:0] pos_a_y;
    logic signed [PosW-1:0] pos_a_z;
    logic signed [PosW-1:0] pos_b_x;
    logic signed [PosW-1:0] pos_b_y;
    logic signed [PosW-1:0] pos_b_z;
  } req_t;

  typedef struct packed {
    logic [TagW-1:0]          out_tag_a;
    logic [TagW-1:0]          out_tag_b;
    logic [EnergyW-1:0]       energy;
    logic signed [ForceW-1:0] force_a_x;
    logic signed [ForceW-1:0] force_a_y;
    logic signed [ForceW-1:0] force_a_z;
    logic signed [ForceW-1:0] force_b_x;
    logic signed [ForceW-1:0] force_b_y;
    logic signed [ForceW-1:0] force_b_z;
    region_e                  region;
  } rsp_t;

  typedef struct packed {
    logic                   repel_mode;
    logic [CfgW-1:0]        force_constant;
    logic signed [CfgW-1:0] flat_limit;
    logic signed [CfgW-1:0] switch_distance;
  } cfg_t;

  // Per-pair data that travels alongside the square root.
  typedef struct packed {
    logic [TagW-1:0]             tag_a;
    logic [TagW-1:0]             tag_b;
    logic [2:0]                  d_neg;
    logic [2:0][DiffW-1:0]       d_mag;
  } geo_t;

  // Per-pair data that travels alongside the force division.
  typedef struct packed {
    logic [TagW-1:0]    tag_a;
    logic [TagW-1:0]    tag_b;
    logic [EnergyW-1:0] energy;
    region_e            region;
    logic [2:0]         f_neg;
    logic               f_zero;
  } fin_t;

endpackage

// ===== hdl/pair_distance_restraint_force.sv =====
// Top level of the pair distance restraint force block: configuration registers,
// difference and square front end, and output stage. Depends on prdr_pkg and all prdr_ modules.
//
// Usage. A request carries two atom tags and two Q11.20 positions on req_i and is taken
// at a rising edge where start is high and busy is low. busy never rises: the block is
// a fully pipelined datapath and takes one request in every clock cycle.
// Each result appears on rsp_o for exactly one cycle with done_o high. A request passes
// through four front-end stages, the square root (one bit per stage, 33 stages), five
// restraint stages, the force divider (one quotient bit per stage, 47 stages) and the
// output register.
// Results leave in request order; the receiver cannot hold them off, so no stall
// path exists and nothing waits inside the pipeline.
// Configuration is a plain write port: cfg_we_i, cfg_index_i and cfg_wdata_i write one
// register per edge. It should be written only while no request is in flight.
// Reset, asynchronous and active low, clears every valid bit and all four registers
// to zero; results in flight are dropped.
module pair_distance_restraint_force #(
  parameter int unsigned ATOM_INDEX_BITS = prdr_pkg::AtomIndexBits,
  parameter int unsigned FRACTION_BITS   = prdr_pkg::FractionBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  prdr_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [prdr_pkg::CfgW-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output prdr_pkg::rsp_t              rsp_o
);

  localparam int unsigned TagW   = prdr_pkg::TagW;
  localparam int unsigned DiffW  = prdr_pkg::DiffW;
  localparam int unsigned SqW    = prdr_pkg::SqW;
  localparam int unsigned SumW   = prdr_pkg::SumW;
  localparam int unsigned RootW  = prdr_pkg::RootW;
  localparam int unsigned FProdW = prdr_pkg::FProdW;
  localparam int unsigned DedrW  = prdr_pkg::DedrW;
  localparam int unsigned ForceW = prdr_pkg::ForceW;
  // Tags are echoed masked to the atom index width.
  localparam logic [TagW-1:0] TagMask = (ATOM_INDEX_BITS >= TagW) ? '1 :
                                        TagW'((32'd1 << ATOM_INDEX_BITS) - 32'd1);

  assign busy = 1'b0;

  // Configuration registers.
  prdr_pkg::cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (prdr_pkg::cfg_index_e'(cfg_index_i))
        prdr_pkg::CfgRepelMode:      cfg_q.repel_mode      <= cfg_wdata_i[0];
        prdr_pkg::CfgForceConstant:  cfg_q.force_constant  <= cfg_wdata_i;
        prdr_pkg::CfgFlatLimit:      cfg_q.flat_limit      <= signed'(cfg_wdata_i);
        prdr_pkg::CfgSwitchDistance: cfg_q.switch_distance <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Front end: request register, difference vector, squares, sum of squares.
  logic                  f1_valid_q, f2_valid_q, f3_valid_q, f4_valid_q;
  prdr_pkg::req_t        f1_req_q;
  prdr_pkg::geo_t        geo_d, f2_geo_q, f3_geo_q, f4_geo_q;
  logic [2:0][SqW-1:0]   f3_sq_q;
  logic [SumW-1:0]       f4_sum_q;

  // The difference of two 32-bit coordinates is exact in 33 bits, and so is its magnitude.
  always_comb begin
    logic signed [DiffW-1:0] d [3];
    d[0] = DiffW'(f1_req_q.pos_a_x) - DiffW'(f1_req_q.pos_b_x);
    d[1] = DiffW'(f1_req_q.pos_a_y) - DiffW'(f1_req_q.pos_b_y);
    d[2] = DiffW'(f1_req_q.pos_a_z) - DiffW'(f1_req_q.pos_b_z);
    geo_d.tag_a = f1_req_q.tag_a;
    geo_d.tag_b = f1_req_q.tag_b;
    for (int i = 0; i < 3; i++) begin
      geo_d.d_neg[i] = d[i][DiffW-1];
      geo_d.d_mag[i] = d[i][DiffW-1] ? DiffW'(-d[i]) : DiffW'(d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
      f4_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= start && !busy;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
      f4_valid_q <= f3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_req_q <= req_i;
    f2_geo_q <= geo_d;
    for (int i = 0; i < 3; i++) begin
      f3_sq_q[i] <= SqW'(f2_geo_q.d_mag[i]) * SqW'(f2_geo_q.d_mag[i]);
    end
    f3_geo_q <= f2_geo_q;
    f4_sum_q <= SumW'(f3_sq_q[0]) + SumW'(f3_sq_q[1]) + SumW'(f3_sq_q[2]);
    f4_geo_q <= f3_geo_q;
  end

  // Distance.
  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  prdr_pkg::geo_t   sq_geo;

  prdr_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f4_valid_q),
    .in_sum_i    (f4_sum_q),
    .in_geo_i    (f4_geo_q),
    .out_valid_o (sq_valid),
    .out_root_o  (sq_root),
    .out_geo_o   (sq_geo)
  );

  // Region, dedr, energy and the force numerators |dedr| * |d_i|.
  logic                    sh_valid;
  logic [2:0][FProdW-1:0]  sh_num;
  logic [RootW-1:0]        sh_den;
  prdr_pkg::fin_t          sh_fin;

  prdr_shape #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (sq_valid),
    .in_root_i   (sq_root),
    .in_geo_i    (sq_geo),
    .out_valid_o (sh_valid),
    .out_num_o   (sh_num),
    .out_den_o   (sh_den),
    .out_fin_o   (sh_fin)
  );

  // Force magnitudes: numerator divided by the distance.
  logic                   dv_valid;
  logic [2:0][DedrW-1:0]  dv_quot;
  prdr_pkg::fin_t         dv_fin;

  prdr_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sh_valid),
    .in_num_i    (sh_num),
    .in_den_i    (sh_den),
    .in_fin_i    (sh_fin),
    .out_valid_o (dv_valid),
    .out_quot_o  (dv_quot),
    .out_fin_o   (dv_fin)
  );

  // Output stage: apply signs, zero the forces of inactive or coincident pairs, and
  // give atom b the negated force.
  logic signed [ForceW-1:0] fa [3];
  logic signed [ForceW-1:0] fb [3];
  always_comb begin
    logic signed [ForceW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = signed'(ForceW'(dv_quot[i]));
      if (dv_fin.f_zero) begin
        fa[i] = '0;
      end else if (dv_fin.f_neg[i]) begin
        fa[i] = -mag;
      end else begin
        fa[i] = mag;
      end
      fb[i] = -fa[i];
    end
  end

  logic done_q;
  prdr_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.out_tag_a <= dv_fin.tag_a & TagMask;
    rsp_q.out_tag_b <= dv_fin.tag_b & TagMask;
    rsp_q.energy    <= dv_fin.energy;
    rsp_q.force_a_x <= fa[0];
    rsp_q.force_a_y <= fa[1];
    rsp_q.force_a_z <= fa[2];
    rsp_q.force_b_x <= fb[0];
    rsp_q.force_b_y <= fb[1];
    rsp_q.force_b_z <= fb[2];
    rsp_q.region    <= dv_fin.region;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hdl/prdr_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage, with side payload.
// Depends on prdr_pkg.
module prdr_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [prdr_pkg::SumW-1:0]     in_sum_i,
  input  prdr_pkg::geo_t                in_geo_i,
  output logic                          out_valid_o,
  output logic [prdr_pkg::RootW-1:0]    out_root_o,
  output prdr_pkg::geo_t                out_geo_o
);

  localparam int unsigned RootW = prdr_pkg::RootW;
  localparam int unsigned RemW  = prdr_pkg::SqRemW;

  logic             valid_q [RootW];
  logic [RemW-1:0]  rem_q   [RootW];
  logic [RootW-1:0] root_q  [RootW];
  prdr_pkg::geo_t   geo_q   [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned B = RootW - 1 - s;
    logic             v_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    prdr_pkg::geo_t   geo_in;
    logic [RemW-1:0]  trial;

    if (s == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = RemW'(in_sum_i);
      assign root_in = '0;
      assign geo_in  = in_geo_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign geo_in  = geo_q[s-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
    assign trial = (RemW'(root_in) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      geo_q[s] <= geo_in;
      if (rem_in >= trial) begin
        rem_q[s]  <= rem_in - trial;
        root_q[s] <= root_in | (RootW'(1) << B);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
    end
  end

  assign out_valid_o = valid_q[RootW-1];
  assign out_root_o  = root_q[RootW-1];
  assign out_geo_o   = geo_q[RootW-1];

endmodule

// ===== hdl/prdr_shape.sv =====
// Restraint region, dedr, energy and force numerators over five register stages.
// Depends on prdr_pkg.
module prdr_shape #(
  parameter int unsigned FRACTION_BITS = prdr_pkg::FractionBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  prdr_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  input  logic [prdr_pkg::RootW-1:0]           in_root_i,
  input  prdr_pkg::geo_t                       in_geo_i,
  output logic                                 out_valid_o,
  output logic [2:0][prdr_pkg::FProdW-1:0]     out_num_o,
  output logic [prdr_pkg::RootW-1:0]           out_den_o,
  output prdr_pkg::fin_t                       out_fin_o
);

  localparam int unsigned DispW   = prdr_pkg::DispW;
  localparam int unsigned DMagW   = prdr_pkg::DMagW;
  localparam int unsigned MMagW   = prdr_pkg::MMagW;
  localparam int unsigned KProdW  = prdr_pkg::KProdW;
  localparam int unsigned DedrW   = prdr_pkg::DedrW;
  localparam int unsigned LoW     = prdr_pkg::DedrLoW;
  localparam int unsigned HiW     = prdr_pkg::DedrHiW;
  localparam int unsigned DiffW   = prdr_pkg::DiffW;
  localparam int unsigned RootW   = prdr_pkg::RootW;
  localparam int unsigned EProdW  = prdr_pkg::EProdW;
  localparam int unsigned FProdW  = prdr_pkg::FProdW;
  localparam int unsigned EnergyW = prdr_pkg::EnergyW;
  localparam int unsigned EShift  = FRACTION_BITS + 1;

  // Stage A: region selection and displacements.
  logic signed [DispW-1:0] r_s, r0_s, r1_s, lim_s, dh_s, len_s, mlin_s, d_s, m_s;
  logic                    active, harm;
  prdr_pkg::region_e       region_d;
  logic [DispW-1:0]        d_abs, m_abs;
  prdr_pkg::fin_t          fin_d;

  always_comb begin
    r_s  = DispW'(signed'({1'b0, in_root_i}));
    r0_s = DispW'(cfg_i.flat_limit);
    r1_s = DispW'(cfg_i.switch_distance);
    lim_s = -r0_s;
    if (!cfg_i.repel_mode) begin
      active = r_s > r0_s;
      harm   = r_s < r1_s;
      dh_s   = r_s - r0_s;
      len_s  = r1_s - r0_s;
      mlin_s = len_s + ((r_s - r1_s) <<< 1);
    end else begin
      active = r_s < lim_s;
      harm   = r_s > r1_s;
      dh_s   = lim_s - r_s;
      len_s  = lim_s - r1_s;
      mlin_s = len_s + ((r1_s - r_s) <<< 1);
    end
    if (!active) begin
      region_d = prdr_pkg::RegionInactive;
      d_s = '0;
      m_s = '0;
    end else if (harm) begin
      region_d = prdr_pkg::RegionHarmonic;
      d_s = dh_s;
      m_s = dh_s;
    end else begin
      region_d = prdr_pkg::RegionLinear;
      d_s = len_s;
      m_s = mlin_s;
    end
    d_abs = d_s[DispW-1] ? DispW'(-d_s) : DispW'(d_s);
    m_abs = m_s[DispW-1] ? DispW'(-m_s) : DispW'(m_s);

    fin_d.tag_a  = in_geo_i.tag_a;
    fin_d.tag_b  = in_geo_i.tag_b;
    fin_d.energy = '0;
    // The energy is kept at zero distance, but the forces are not.
    fin_d.region = (in_root_i == '0) ? prdr_pkg::RegionZero : region_d;
    fin_d.f_zero = (in_root_i == '0) || (region_d == prdr_pkg::RegionInactive);
    for (int i = 0; i < 3; i++) begin
      fin_d.f_neg[i] = d_s[DispW-1] ^ in_geo_i.d_neg[i] ^ !cfg_i.repel_mode;
    end
  end

  logic                  a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q;
  logic [DMagW-1:0]      a_dmag_q;
  logic [MMagW-1:0]      a_mmag_q, b_mmag_q, c_mmag_q;
  logic                  a_dneg_q, b_dneg_q, a_mneg_q, b_mneg_q;
  logic [2:0][DiffW-1:0] a_dmag3_q, b_dmag3_q, c_dmag3_q;
  logic [RootW-1:0]      a_root_q, b_root_q, c_root_q, d_root_q, e_root_q;
  prdr_pkg::fin_t        a_fin_q, b_fin_q, c_fin_q, d_fin_q, e_fin_q;
  logic [KProdW-1:0]     b_kprod_q;
  logic [DedrW-1:0]      c_dedr_q;
  logic                  c_eok_q, d_eok_q, e_eok_q;
  logic [LoW+MMagW-1:0]  d_elo_q;
  logic [HiW+MMagW-1:0]  d_ehi_q;
  logic [2:0][LoW+DiffW-1:0] d_flo_q;
  logic [2:0][HiW+DiffW-1:0] d_fhi_q;
  logic [EProdW-1:0]     e_eprod_q;
  logic [2:0][FProdW-1:0] e_fprod_q;

  // Stage C logic: dedr magnitude with saturation at 2^47 - 1.
  logic [KProdW-9:0] k_shift;
  logic [DedrW-1:0]  dedr_d;
  logic              eok_d;
  always_comb begin
    k_shift = b_kprod_q[KProdW-1:8];
    dedr_d  = (|k_shift[KProdW-9:DedrW]) ? '1 : k_shift[DedrW-1:0];
    eok_d   = (dedr_d != '0) && (b_mmag_q != '0) && (b_dneg_q == b_mneg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage A
    a_dmag_q  <= d_abs[DMagW-1:0];
    a_mmag_q  <= m_abs[MMagW-1:0];
    a_dneg_q  <= d_s[DispW-1];
    a_mneg_q  <= m_s[DispW-1];
    a_dmag3_q <= in_geo_i.d_mag;
    a_root_q  <= in_root_i;
    a_fin_q   <= fin_d;
    // Stage B: spring constant times displacement.
    b_kprod_q <= KProdW'(cfg_i.force_constant) * KProdW'(a_dmag_q);
    b_mmag_q  <= a_mmag_q;
    b_dneg_q  <= a_dneg_q;
    b_mneg_q  <= a_mneg_q;
    b_dmag3_q <= a_dmag3_q;
    b_root_q  <= a_root_q;
    b_fin_q   <= a_fin_q;
    // Stage C
    c_dedr_q  <= dedr_d;
    c_eok_q   <= eok_d;
    c_mmag_q  <= b_mmag_q;
    c_dmag3_q <= b_dmag3_q;
    c_root_q  <= b_root_q;
    c_fin_q   <= b_fin_q;
    // Stage D: partial products on the two halves of dedr.
    d_elo_q <= (LoW+MMagW)'(c_dedr_q[LoW-1:0]) * (LoW+MMagW)'(c_mmag_q);
    d_ehi_q <= (HiW+MMagW)'(c_dedr_q[DedrW-1:LoW]) * (HiW+MMagW)'(c_mmag_q);
    for (int i = 0; i < 3; i++) begin
      d_flo_q[i] <= (LoW+DiffW)'(c_dedr_q[LoW-1:0]) * (LoW+DiffW)'(c_dmag3_q[i]);
      d_fhi_q[i] <= (HiW+DiffW)'(c_dedr_q[DedrW-1:LoW]) * (HiW+DiffW)'(c_dmag3_q[i]);
    end
    d_eok_q  <= c_eok_q;
    d_root_q <= c_root_q;
    d_fin_q  <= c_fin_q;
    // Stage E: combine partial products.
    e_eprod_q <= (EProdW'(d_ehi_q) << LoW) + EProdW'(d_elo_q);
    for (int i = 0; i < 3; i++) begin
      e_fprod_q[i] <= (FProdW'(d_fhi_q[i]) << LoW) + FProdW'(d_flo_q[i]);
    end
    e_eok_q  <= d_eok_q;
    e_root_q <= d_root_q;
    e_fin_q  <= d_fin_q;
  end

  // Energy is the product shifted by one more than the fraction bits, saturated, or zero when e_eok_q is clear.
  logic [EProdW-1:0] e_shift;
  always_comb begin
    e_shift   = e_eprod_q >> EShift;
    out_fin_o = e_fin_q;
    if (!e_eok_q) begin
      out_fin_o.energy = '0;
    end else if (|e_shift[EProdW-1:EnergyW]) begin
      out_fin_o.energy = '1;
    end else begin
      out_fin_o.energy = e_shift[EnergyW-1:0];
    end
  end

  assign out_valid_o = e_valid_q;
  assign out_num_o   = e_fprod_q;
  assign out_den_o   = e_root_q;

endmodule

// ===== hdl/prdr_divide.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on prdr_pkg.
module prdr_divide (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [2:0][prdr_pkg::FProdW-1:0]     in_num_i,
  input  logic [prdr_pkg::RootW-1:0]           in_den_i,
  input  prdr_pkg::fin_t                       in_fin_i,
  output logic                                 out_valid_o,
  output logic [2:0][prdr_pkg::DedrW-1:0]      out_quot_o,
  output prdr_pkg::fin_t                       out_fin_o
);

  localparam int unsigned QW = prdr_pkg::DedrW;
  localparam int unsigned DW = prdr_pkg::RootW;
  localparam int unsigned NW = prdr_pkg::FProdW;

  // The quotient stays below 2^47 because each component is at most the distance,
  // so the bits of the numerator above bit 46 already form a partial remainder.
  logic                 valid_q [QW];
  logic [2:0][DW-1:0]   rem_q   [QW];
  logic [2:0][QW-1:0]   nq_q    [QW];
  logic [DW-1:0]        den_q   [QW];
  prdr_pkg::fin_t       fin_q   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic               v_in;
    logic [2:0][DW-1:0] rem_in, rem_nx;
    logic [2:0][QW-1:0] nq_in, nq_nx;
    logic [DW-1:0]      den_in;
    prdr_pkg::fin_t     fin_in;

    if (s == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign den_in = in_den_i;
      assign fin_in = in_fin_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = in_num_i[l][NW-1:QW];
        assign nq_in[l]  = in_num_i[l][QW-1:0];
      end
    end else begin : g_next
      assign v_in   = valid_q[s-1];
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
      assign fin_in = fin_q[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      for (int l = 0; l < 3; l++) begin
        t = {rem_in[l], nq_in[l][QW-1]};
        if (t >= {1'b0, den_in}) begin
          rem_nx[l] = DW'(t - {1'b0, den_in});
          nq_nx[l]  = {nq_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nx[l] = t[DW-1:0];
          nq_nx[l]  = {nq_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_nx;
      nq_q[s]  <= nq_nx;
      den_q[s] <= den_in;
      fin_q[s] <= fin_in;
    end
  end

  assign out_valid_o = valid_q[QW-1];
  assign out_quot_o  = nq_q[QW-1];
  assign out_fin_o   = fin_q[QW-1];

endmodule
